// ===== src/ctt_pkg.sv =====
// ----------------------------------------------------------------------------
// ctt_pkg
// Shared codes, widths and controller/datapath interface types for the
// connection timer table.
// ----------------------------------------------------------------------------
package ctt_pkg;

  localparam int FUNC_W  = 2;
  localparam int ID_W    = 4;
  localparam int COUNT_W = 5;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_SET    = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_SWEEP  = 2'd2
  } func_t;

  typedef struct packed {
    logic load;
    logic apply;
    logic scan;
    logic emit;
    logic finish;
  } ctt_cmd_t;

  typedef struct packed {
    logic sweep;
    logic scan_done;
    logic emit_last;
  } ctt_status_t;

endpackage

// ===== src/ctt_ctrl.sv =====
// ----------------------------------------------------------------------------
// ctt_ctrl
// Operation sequencer: apply, scan all slots, walk the expired map (sweep only), close.
// ----------------------------------------------------------------------------
module ctt_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  output ctt_pkg::ctt_cmd_t    cmd,
  input  ctt_pkg::ctt_status_t status
);
  import ctt_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_APPLY = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_EMIT  = 5'b01000,
    ST_FINAL = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) state_next = ST_APPLY;
      end
      ST_APPLY: state_next = ST_SCAN;
      ST_SCAN: begin
        if (status.scan_done) state_next = status.sweep ? ST_EMIT : ST_FINAL;
      end
      ST_EMIT: begin
        if (status.emit_last) state_next = ST_FINAL;
      end
      ST_FINAL: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy       = (state != ST_IDLE);
  assign cmd.load   = (state == ST_IDLE) && start;
  assign cmd.apply  = (state == ST_APPLY);
  assign cmd.scan   = (state == ST_SCAN);
  assign cmd.emit   = (state == ST_EMIT);
  assign cmd.finish = (state == ST_FINAL);

  a_accept_to_apply: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> state == ST_APPLY)
    else $error("accepted beat did not enter apply");

  a_emit_to_final: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT && status.emit_last |=> state == ST_FINAL)
    else $error("emit walk did not close");

endmodule

// ===== src/ctt_datapath.sv =====
// ----------------------------------------------------------------------------
// ctt_datapath
// Slot table, valid and expired maps, scan accumulators and result registers.
// ----------------------------------------------------------------------------
module ctt_datapath #(
  parameter int SLOTS     = 16,
  parameter int TIME_BITS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ctt_pkg::ctt_cmd_t             cmd,
  output ctt_pkg::ctt_status_t          status,
  input  logic [ctt_pkg::FUNC_W-1:0]    func,
  input  logic [ctt_pkg::ID_W-1:0]      conn_id,
  input  logic [TIME_BITS-1:0]          time_value,
  output logic                          result_valid,
  output logic                          expired_valid,
  output logic [ctt_pkg::ID_W-1:0]      expired_conn_id,
  output logic [TIME_BITS-1:0]          next_expiry,
  output logic [ctt_pkg::COUNT_W-1:0]   entry_count,
  output logic                          last
);
  import ctt_pkg::*;

  localparam int SW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  logic [TIME_BITS-1:0] mem [SLOTS];

  logic [FUNC_W-1:0]    op_func;
  logic [ID_W-1:0]      op_id;
  logic [TIME_BITS-1:0] op_time;
  logic [SLOTS-1:0]     valid;
  logic [SLOTS-1:0]     expired;
  logic [SW:0]          scan_idx;
  logic [SW-1:0]        rd_idx;
  logic                 rd_live;
  logic [TIME_BITS-1:0] rd_data;
  logic [TIME_BITS-1:0] min_acc;
  logic [CW-1:0]        cnt_acc;
  logic [SW-1:0]        emit_idx;

  logic          id_ok;
  logic [SW-1:0] slot;
  logic          time_inf;
  logic          scan_more;
  logic          hit;
  logic          mem_wr;

  assign id_ok     = 32'(op_id) < SLOTS;
  assign slot      = SW'(op_id);
  assign time_inf  = (op_time == '1);
  assign scan_more = scan_idx < (SW+1)'(SLOTS);
  assign hit       = (op_func == FUNC_SWEEP) && (rd_data <= op_time);
  assign mem_wr    = cmd.apply && id_ok && (op_func == FUNC_SET) && !time_inf;

  assign status.sweep     = (op_func == FUNC_SWEEP);
  assign status.scan_done = !scan_more && !rd_live;
  assign status.emit_last = (emit_idx == SW'(SLOTS - 1));

  // expiry store, registered read
  always_ff @(posedge clk) begin
    if (mem_wr) begin
      mem[slot] <= op_time;
    end
    if (cmd.scan && scan_more) begin
      rd_data <= mem[scan_idx[SW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid        <= '0;
      expired      <= '0;
      rd_live      <= 1'b0;
      cnt_acc      <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (cmd.load) begin
        op_func  <= func;
        op_id    <= conn_id;
        op_time  <= time_value;
        expired  <= '0;
        scan_idx <= '0;
        rd_live  <= 1'b0;
        min_acc  <= '1;
        cnt_acc  <= '0;
        emit_idx <= '0;
      end
      if (cmd.apply && id_ok) begin
        if (op_func == FUNC_SET) begin
          valid[slot] <= !time_inf;
        end else if (op_func == FUNC_REMOVE) begin
          valid[slot] <= 1'b0;
        end
      end
      if (cmd.scan) begin
        rd_live <= scan_more;
        if (scan_more) begin
          rd_idx   <= scan_idx[SW-1:0];
          scan_idx <= scan_idx + 1'b1;
        end
        // rd_data belongs to the slot issued in the previous cycle
        if (rd_live && valid[rd_idx]) begin
          if (hit) begin
            valid[rd_idx]   <= 1'b0;
            expired[rd_idx] <= 1'b1;
          end else begin
            cnt_acc <= CW'(cnt_acc + 1'b1);
            if (rd_data < min_acc) min_acc <= rd_data;
          end
        end
      end
      if (cmd.emit) begin
        result_valid    <= expired[emit_idx];
        expired_valid   <= 1'b1;
        expired_conn_id <= ID_W'(emit_idx);
        next_expiry     <= min_acc;
        entry_count     <= COUNT_W'(cnt_acc);
        last            <= 1'b0;
        emit_idx        <= emit_idx + 1'b1;
      end
      if (cmd.finish) begin
        result_valid    <= 1'b1;
        expired_valid   <= 1'b0;
        expired_conn_id <= '0;
        next_expiry     <= min_acc;
        entry_count     <= COUNT_W'(cnt_acc);
        last            <= 1'b1;
      end
    end
  end

  a_expired_cleared: assert property (@(posedge clk) disable iff (rst)
    (expired & valid) == '0)
    else $error("expired slot still marked valid");

  a_last_no_id: assert property (@(posedge clk) disable iff (rst)
    result_valid && last |-> !expired_valid)
    else $error("closing beat carries an expired id");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    32'(cnt_acc) <= SLOTS)
    else $error("entry count above slot count");

endmodule

// ===== src/connection_timer_table.sv =====
// ----------------------------------------------------------------------------
// connection_timer_table
// Per-connection expiry table with set, remove and expired-slot sweep.
// ----------------------------------------------------------------------------
// Command channel: an operation (func, conn_id, time_value) is taken at a
// rising edge with start high and busy low. busy stays high until every
// result of that operation has been driven.
// Result channel: each result is on the result ports for one cycle, marked
// by result_valid; the receiver cannot stall it. Set and remove give one
// result with last high. A sweep gives one result per expired slot, in
// ascending id order, then a closing result with last high and no id.
// next_expiry and entry_count always describe the table after the whole
// operation.
// Sequence: an apply step, then a scan of every slot through the single read
// port of the expiry store, then (sweep only) a walk of the expired map,
// then a closing step. The last result shows in the cycle after that, which
// is also the first cycle a new command can be taken.
// Reset: rst (synchronous) empties the table; expiry values need no clear.
// ----------------------------------------------------------------------------
module connection_timer_table #(
  parameter int SLOTS     = 16,
  parameter int TIME_BITS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [ctt_pkg::FUNC_W-1:0]    func,
  input  logic [ctt_pkg::ID_W-1:0]      conn_id,
  input  logic [TIME_BITS-1:0]          time_value,
  output logic                          result_valid,
  output logic                          expired_valid,
  output logic [ctt_pkg::ID_W-1:0]      expired_conn_id,
  output logic [TIME_BITS-1:0]          next_expiry,
  output logic [ctt_pkg::COUNT_W-1:0]   entry_count,
  output logic                          last
);
  import ctt_pkg::*;

  ctt_cmd_t    cmd;
  ctt_status_t status;

  ctt_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .status (status)
  );

  ctt_datapath #(
    .SLOTS     (SLOTS),
    .TIME_BITS (TIME_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .func            (func),
    .conn_id         (conn_id),
    .time_value      (time_value),
    .result_valid    (result_valid),
    .expired_valid   (expired_valid),
    .expired_conn_id (expired_conn_id),
    .next_expiry     (next_expiry),
    .entry_count     (entry_count),
    .last            (last)
  );

endmodule
